[rtl/u2u8_pkg.sv]
// Package: shared types, constants and the code point byte encoder.
`default_nettype none
package u2u8_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned HighW = 10;

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [CpW-1:0]   SuppBase  = 21'h10000;
  localparam logic [5:0]       SurrTag   = 6'b110110;

  localparam logic [CpW-1:0] Lim1 = 21'h80;
  localparam logic [CpW-1:0] Lim2 = 21'h800;
  localparam logic [CpW-1:0] Lim3 = 21'h10000;

  localparam logic [ByteW-1:0] ContTag  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Tag = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Tag = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Tag = 8'hF0;

  // Which code point of a queue entry the back end is working on.
  typedef enum logic {
    SEG_PRE,
    SEG_MAIN
  } seg_e;

  // One queue entry: an optional flushed high surrogate, then an optional code point.
  typedef struct packed {
    logic             pre_valid;
    logic [HighW-1:0] pre_hi;
    logic             main_valid;
    logic [CpW-1:0]   main_cp;
  } entry_t;

  typedef struct packed {
    logic [3:0][ByteW-1:0] bytes;
    logic [1:0]            last_idx;
  } cp_enc_t;

  function automatic cp_enc_t encode_cp(input logic [CpW-1:0] cp);
    cp_enc_t e;
    e.bytes    = '0;
    e.last_idx = 2'd0;
    if (cp < Lim1) begin
      e.bytes[0] = cp[7:0];
    end else if (cp < Lim2) begin
      e.bytes[0] = Lead2Tag | {3'b000, cp[10:6]};
      e.bytes[1] = ContTag | {2'b00, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp < Lim3) begin
      e.bytes[0] = Lead3Tag | {4'b0000, cp[15:12]};
      e.bytes[1] = ContTag | {2'b00, cp[11:6]};
      e.bytes[2] = ContTag | {2'b00, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = Lead4Tag | {5'b00000, cp[20:18]};
      e.bytes[1] = ContTag | {2'b00, cp[17:12]};
      e.bytes[2] = ContTag | {2'b00, cp[11:6]};
      e.bytes[3] = ContTag | {2'b00, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

[rtl/u2u8_if.sv]
// Interfaces: code unit input channel and byte output channel.
`default_nettype none
interface u2u8_in_if;
  logic                           valid;
  logic                           ready;
  logic [u2u8_pkg::UnitW-1:0]     code_unit;
  logic                           is_final;

  modport source (output valid, output code_unit, output is_final, input ready);
  modport sink   (input valid, input code_unit, input is_final, output ready);
endinterface

interface u2u8_out_if;
  logic                           valid;
  logic                           ready;
  logic [u2u8_pkg::ByteW-1:0]     out_byte;
  logic                           run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

[rtl/u2u8_front.sv]
// Front end: accepts code units, pairs surrogates, pushes code point jobs.
`default_nettype none
module u2u8_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  u2u8_in_if.sink            unit_i,
  input  wire                full_i,
  output logic               push_o,
  output u2u8_pkg::entry_t   entry_o
);

  logic                         held_valid_q, held_valid_d;
  logic [u2u8_pkg::HighW-1:0]   held_high_q, held_high_d;
  logic                         accept;
  logic                         is_high, is_low;

  assign unit_i.ready = !full_i;
  assign accept       = unit_i.valid && !full_i;

  always_comb begin
    is_high = unit_i.code_unit inside {[u2u8_pkg::HighFirst:u2u8_pkg::HighLast]};
    is_low  = unit_i.code_unit inside {[u2u8_pkg::LowFirst:u2u8_pkg::LowLast]};
  end

  always_comb begin
    entry_o.pre_valid  = 1'b0;
    entry_o.pre_hi     = held_high_q;
    entry_o.main_valid = 1'b1;
    entry_o.main_cp    = {5'b00000, unit_i.code_unit};
    held_valid_d       = held_valid_q;
    held_high_d        = held_high_q;
    if (accept) begin
      if (held_valid_q && is_low) begin
        // surrogate pair -> supplementary code point
        entry_o.main_cp = u2u8_pkg::SuppBase
                        + {1'b0, held_high_q, 10'b0}
                        + {11'b0, unit_i.code_unit[9:0]};
        held_valid_d    = 1'b0;
        held_high_d     = '0;
      end else begin
        entry_o.pre_valid = held_valid_q;
        if (is_high && !unit_i.is_final) begin
          entry_o.main_valid = 1'b0;
          held_valid_d       = 1'b1;
          held_high_d        = unit_i.code_unit[9:0];
        end else begin
          held_valid_d = 1'b0;
          held_high_d  = '0;
        end
      end
    end
  end

  assign push_o = accept && (entry_o.pre_valid || entry_o.main_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_high_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_high_q  <= held_high_d;
    end
  end

endmodule
`default_nettype wire

[rtl/u2u8_queue.sv]
// Small register FIFO between front and back ends.
`default_nettype none
module u2u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  u2u8_pkg::entry_t   entry_i,
  input  wire                pop_i,
  output u2u8_pkg::entry_t   head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u2u8_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

[rtl/u2u8_back.sv]
// Back end: walks queue entries and emits one UTF-8 byte per beat.
`default_nettype none
module u2u8_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  u2u8_pkg::entry_t   head_i,
  input  wire                empty_i,
  output logic               pop_o,
  u2u8_out_if.source         byte_o
);

  u2u8_pkg::entry_t             entry_q, entry_d;
  u2u8_pkg::seg_e               seg_q, seg_d;
  logic [1:0]                   idx_q, idx_d;
  logic                         busy_q, busy_d;
  logic                         out_valid_q, out_valid_d;
  logic [u2u8_pkg::ByteW-1:0]   byte_q, byte_d;
  logic                         last_q, last_d;
  logic [u2u8_pkg::CpW-1:0]     cur_cp;
  u2u8_pkg::cp_enc_t            enc;
  logic                         emit, seg_end, entry_end;

  always_comb begin
    if (seg_q == u2u8_pkg::SEG_PRE) begin
      cur_cp = {5'b00000, u2u8_pkg::SurrTag, entry_q.pre_hi};
    end else begin
      cur_cp = entry_q.main_cp;
    end
    enc       = u2u8_pkg::encode_cp(cur_cp);
    seg_end   = (idx_q == enc.last_idx);
    entry_end = seg_end && ((seg_q == u2u8_pkg::SEG_MAIN) || !entry_q.main_valid);
    emit      = busy_q && (!out_valid_q || byte_o.ready);
    pop_o     = !empty_i && (!busy_q || (emit && entry_end));
  end

  always_comb begin
    entry_d     = entry_q;
    seg_d       = seg_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !byte_o.ready;
    byte_d      = byte_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      byte_d      = enc.bytes[idx_q];
      last_d      = entry_end;
      if (entry_end) begin
        busy_d = 1'b0;
      end else if (seg_end) begin
        seg_d = u2u8_pkg::SEG_MAIN;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (pop_o) begin
      entry_d = head_i;
      busy_d  = 1'b1;
      idx_d   = 2'd0;
      seg_d   = head_i.pre_valid ? u2u8_pkg::SEG_PRE : u2u8_pkg::SEG_MAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seg_q       <= u2u8_pkg::SEG_MAIN;
      idx_q       <= 2'd0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      seg_q       <= seg_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = byte_q;
  assign byte_o.run_last = last_q;

endmodule
`default_nettype wire

[rtl/utf16_to_utf8_encoder_unit.sv]
// Top level: UTF-16 code unit stream in, UTF-8 byte stream out.
//
//  channel | dir | payload                          | beat
//  unit_i  | in  | code_unit[15:0], is_final        | one UTF-16 code unit
//  byte_o  | out | out_byte[7:0], run_last          | one UTF-8 byte
//
// Output rate is one byte per cycle while byte_o is ready, set by the back
// end's byte walker: a BMP unit yields 1..3 bytes, a surrogate pair 4 (on
// the low unit), plus 3 more when a held high surrogate is flushed first.
// A held high surrogate, with is_final clear, pushes no entry of its own.
// Front and back are split by a QUEUE_DEPTH entry queue; the front stalls
// only when the queue is full, the back only when byte_o is not ready.
// From input to first byte an entry passes the queue, the back end's entry
// register and then the byte register.
// Reset clears the held surrogate, the queue count and the output valid.
`default_nettype none
module utf16_to_utf8_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  u2u8_in_if.sink      unit_i,
  u2u8_out_if.source   byte_o
);

  u2u8_pkg::entry_t push_entry;
  u2u8_pkg::entry_t head_entry;
  logic             push, pop, full, empty;

  // Classifies units and tracks the held high surrogate.
  u2u8_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .unit_i  (unit_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decouples classification from byte emission.
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Serialises each entry's code points into bytes, one per beat.
  u2u8_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .byte_o  (byte_o)
  );

endmodule
`default_nettype wire

[rtl/u2u8_checker.sv]
// Port level checks on the encoder's output stream, bound to the top level.
`default_nettype none
module u2u8_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  wire [7:0]  out_byte_i,
  input  wire        run_last_i
);

  // Stalled beat holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(run_last_i))
    else $error("output beat changed while stalled");

  // A single byte (ASCII) code point always closes its run.
  a_ascii_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_i[7] |-> run_last_i)
    else $error("ASCII byte not marked last of run");

  // No lead byte beyond a 4-byte sequence, no overlong two byte lead.
  a_lead_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_byte_i[7:3] != 5'b11111) && (out_byte_i[7:1] != 7'b1100000))
    else $error("illegal UTF-8 lead byte");

  // Output valid is low by the edge after reset is seen.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind utf16_to_utf8_encoder_unit u2u8_checker u_u2u8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.out_byte),
  .run_last_i  (byte_o.run_last)
);
`default_nettype wire
